// ===== rtl/issc_pkg.sv =====
// Shared types, codes and constants for the image slot store with CRC check.
// Holds the operation and status codes, stream widths and the CRC-32 byte step.
// No dependencies.
package issc_pkg;

    localparam int SLOTS_DEF      = 1;
    localparam int SLOT_BYTES_DEF = 65536;

    localparam int IN_W   = 128;  // 3 + 8 + 64 + 4 + 17 + 32
    localparam int OUT_W  = 120;  // 3 + 64 + 17 + 32, padded to bytes
    localparam int SIZE_W = 17;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_ERASE = 3'd0,
        OP_BEGIN = 3'd1,
        OP_APPEND = 3'd2,
        OP_END = 3'd3,
        OP_ABORT = 3'd4,
        OP_READ = 3'd5,
        OP_INFO = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        STS_OK = 3'd0,
        STS_INVALID = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_NO_SESSION = 3'd3,
        STS_NO_SPACE = 3'd4,
        STS_CRC_MISMATCH = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_APPEND,
        ST_READ,
        ST_FINISH
    } t_state;

    // Reflected CRC-32 over one byte: eight shift-and-xor steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== rtl/issc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the image byte store. No dependencies.
module issc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/image_slot_store_crc_check.sv =====
// Image slot store with CRC-32 check: staging buffer for firmware images.
// Depends on issc_pkg and issc_ram (the image byte store).
//
// Each request transfer produces exactly one response transfer. Erase, begin
// write, end write, abort, info and every rejected request go from decode
// straight to the finish step, which loads the response register. An append
// or read that goes ahead passes through a byte loop first, because the image
// store is a byte-wide RAM with one write and one read port, moved one byte
// per cycle, and on an append the CRC advances one byte per cycle with it. One
// request is processed at a time. The input is ready again in the cycle after
// the response register is loaded, even if that response is still waiting for
// the sink. A response register that is still full holds the block in its
// last step until the sink takes the response. The input is not ready
// during reset. The image store needs no clearing after reset: reads are
// bounds-checked against the size of a completed image.
module image_slot_store_crc_check #(
    parameter int SLOTS      = issc_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = issc_pkg::SLOT_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // operation[2:0], slot[10:3], write_data[74:11], byte_count[78:75],
    // offset[95:79], expected_crc[127:96]
    input  logic [issc_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // status[2:0], read_data[66:3], image_size[83:67], crc_value[115:84], zero pad
    output logic [issc_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import issc_pkg::*;

    localparam int DEPTH = SLOTS * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W = $clog2(SLOT_BYTES + 1);
    localparam int CW    = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 1;

    // captured request
    logic [2:0]        r_op, n_op;
    logic [7:0]        r_slot, n_slot;
    logic [63:0]       r_wdata, n_wdata;
    logic [3:0]        r_count, n_count;
    logic [SIZE_W-1:0] r_off, n_off;
    logic [31:0]       r_exp, n_exp;

    t_state r_state, n_state;

    // slot table and session
    logic [SLOTS-1:0]  r_slot_valid, n_slot_valid;
    logic [LEN_W-1:0]  r_slot_size [SLOTS];
    logic [LEN_W-1:0]  n_slot_size [SLOTS];
    logic [31:0]       r_slot_crc [SLOTS];
    logic [31:0]       n_slot_crc [SLOTS];
    logic              r_sess_open, n_sess_open;
    logic [SW-1:0]     r_sess_slot, n_sess_slot;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [31:0]       r_crc, n_crc;

    // byte loop
    logic [AW-1:0]     r_addr, n_addr;
    logic [3:0]        r_idx, n_idx;
    logic              r_rd_pend, n_rd_pend;
    logic [2:0]        r_rd_pos, n_rd_pos;

    // result being built, and the response register
    logic [2:0]        r_res_status, n_res_status;
    logic [63:0]       r_res_rdata, n_res_rdata;
    logic [SIZE_W-1:0] r_res_size, n_res_size;
    logic [31:0]       r_res_crc, n_res_crc;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    // RAM port
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_wbyte;
    logic [7:0]        ram_rdata;

    logic              s_accept;
    logic              slot_ok;
    logic [SW-1:0]     idx;
    logic [AW-1:0]     base;
    logic [31:0]       crc_fin;

    issc_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wbyte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign slot_ok   = (32'(r_slot) < 32'(SLOTS));
    assign idx       = slot_ok ? r_slot[SW-1:0] : '0;
    assign crc_fin   = ~r_crc;
    assign ram_wbyte = r_wdata[{r_idx[2:0], 3'b000} +: 8];
    assign ram_raddr = r_addr;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_slot       = r_slot;
        n_wdata      = r_wdata;
        n_count      = r_count;
        n_off        = r_off;
        n_exp        = r_exp;
        n_slot_valid = r_slot_valid;
        n_slot_size  = r_slot_size;
        n_slot_crc   = r_slot_crc;
        n_sess_open  = r_sess_open;
        n_sess_slot  = r_sess_slot;
        n_len        = r_len;
        n_crc        = r_crc;
        n_addr       = r_addr;
        n_idx        = r_idx;
        n_rd_pend    = 1'b0;
        n_rd_pos     = r_idx[2:0];
        n_res_status = r_res_status;
        n_res_rdata  = r_res_rdata;
        n_res_size   = r_res_size;
        n_res_crc    = r_res_crc;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;
        base         = '0;

        // land the byte read in the previous cycle
        if (r_rd_pend) begin
            n_res_rdata[{r_rd_pos, 3'b000} +: 8] = ram_rdata;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_op    = i_s_axis_tdata[2:0];
                    n_slot  = i_s_axis_tdata[10:3];
                    n_wdata = i_s_axis_tdata[74:11];
                    n_count = i_s_axis_tdata[78:75];
                    n_off   = i_s_axis_tdata[95:79];
                    n_exp   = i_s_axis_tdata[127:96];
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                n_res_status = STS_OK;
                n_res_rdata  = '0;
                n_res_size   = '0;
                n_res_crc    = '0;
                n_idx        = '0;
                n_state      = ST_FINISH;
                case (r_op)
                    OP_ERASE: begin
                        if (!slot_ok) begin
                            n_res_status = STS_INVALID;
                        end else begin
                            if (r_sess_open && (r_sess_slot == idx)) begin
                                n_sess_open = 1'b0;
                            end
                            n_slot_valid[idx] = 1'b0;
                        end
                    end
                    OP_BEGIN: begin
                        if (!slot_ok) begin
                            n_res_status = STS_INVALID;
                        end else begin
                            n_slot_valid[idx] = 1'b0;
                            n_sess_open       = 1'b1;
                            n_sess_slot       = idx;
                            n_len             = '0;
                            n_crc             = CRC_INIT;
                        end
                    end
                    OP_APPEND: begin
                        base = AW'(32'(r_sess_slot) * SLOT_BYTES);
                        if (!r_sess_open) begin
                            n_res_status = STS_NO_SESSION;
                        end else if (r_count > 4'd8) begin
                            n_res_status = STS_INVALID;
                        end else if ((CW'(r_len) + CW'(r_count)) > CW'(SLOT_BYTES)) begin
                            n_res_status = STS_NO_SPACE;
                        end else begin
                            n_addr  = base + AW'(r_len);
                            n_state = ST_APPEND;
                        end
                    end
                    OP_END: begin
                        if (!r_sess_open) begin
                            n_res_status = STS_NO_SESSION;
                        end else begin
                            n_res_crc   = crc_fin;
                            n_sess_open = 1'b0;
                            if (crc_fin != r_exp) begin
                                n_res_status = STS_CRC_MISMATCH;
                            end else begin
                                n_slot_size[r_sess_slot]  = r_len;
                                n_slot_crc[r_sess_slot]   = crc_fin;
                                n_slot_valid[r_sess_slot] = 1'b1;
                            end
                        end
                    end
                    OP_ABORT: begin
                        n_sess_open = 1'b0;
                    end
                    OP_READ: begin
                        base = AW'(32'(idx) * SLOT_BYTES);
                        if (!slot_ok || !r_slot_valid[idx] || (r_count > 4'd8)) begin
                            n_res_status = STS_INVALID;
                        end else if ((CW'(r_off) + CW'(r_count)) > CW'(r_slot_size[idx])) begin
                            n_res_status = STS_INVALID;
                        end else begin
                            n_addr  = base + AW'(r_off);
                            n_state = ST_READ;
                        end
                    end
                    OP_INFO: begin
                        if (!slot_ok) begin
                            n_res_status = STS_INVALID;
                        end else if (!r_slot_valid[idx]) begin
                            n_res_status = STS_NOT_FOUND;
                        end else begin
                            n_res_size = SIZE_W'(r_slot_size[idx]);
                            n_res_crc  = r_slot_crc[idx];
                        end
                    end
                    default: begin
                        n_res_status = STS_INVALID;
                    end
                endcase
            end
            ST_APPEND: begin
                if (r_idx == r_count) begin
                    n_len   = r_len + LEN_W'(r_count);
                    n_state = ST_FINISH;
                end else begin
                    ram_we = 1'b1;
                    n_crc  = crc_byte(r_crc, ram_wbyte);
                    n_addr = r_addr + AW'(1);
                    n_idx  = r_idx + 4'd1;
                end
            end
            ST_READ: begin
                // the last byte lands on the same edge that leaves this state
                if (r_idx == r_count) begin
                    n_state = ST_FINISH;
                end else begin
                    n_rd_pend = 1'b1;
                    n_addr    = r_addr + AW'(1);
                    n_idx     = r_idx + 4'd1;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'd0, r_res_crc, r_res_size, r_res_rdata, r_res_status};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= '0;
            r_sess_open  <= 1'b0;
            r_sess_slot  <= '0;
            r_len        <= '0;
            r_crc        <= CRC_INIT;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_sess_open  <= n_sess_open;
            r_sess_slot  <= n_sess_slot;
            r_len        <= n_len;
            r_crc        <= n_crc;
            r_rd_pend    <= n_rd_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_wdata      <= n_wdata;
        r_count      <= n_count;
        r_off        <= n_off;
        r_exp        <= n_exp;
        r_slot_size  <= n_slot_size;
        r_slot_crc   <= n_slot_crc;
        r_addr       <= n_addr;
        r_idx        <= n_idx;
        r_rd_pos     <= n_rd_pos;
        r_res_status <= n_res_status;
        r_res_rdata  <= n_res_rdata;
        r_res_size   <= n_res_size;
        r_res_crc    <= n_res_crc;
        r_out_data   <= n_out_data;
    end

    a_accept_to_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == ST_DEC))
        else $error("accepted request did not enter decode");

    a_write_in_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_APPEND) && r_sess_open))
        else $error("image write outside an open append");

    a_read_pend_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> $past(r_state == ST_READ))
        else $error("read data pending without a read issue");

    a_finish_no_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_APPEND) || (r_state == ST_READ)) |-> (r_idx <= r_count))
        else $error("byte index ran past the byte count");

endmodule
